>>> rtl/line_cone_clipper_assert.svh
`ifndef LINE_CONE_CLIPPER_ASSERT_SVH
`define LINE_CONE_CLIPPER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcc_pkg.sv
`default_nettype none

package lcc_pkg;

  localparam int COORD_W = 32;
  localparam int GAIN_W  = 17;
  localparam int DIGIT   = 16;

  localparam logic [GAIN_W-1:0] RADIAL_RESET = 17'd40632;
  localparam logic [GAIN_W-1:0] AXIAL_RESET  = 17'd24904;

  typedef enum logic [0:0] {
    CFG_RADIAL = 1'b0,
    CFG_AXIAL  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } in_beat_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [COORD_W-1:0] clip_start_x;
    logic signed [COORD_W-1:0] clip_start_y;
    logic signed [COORD_W-1:0] clip_start_z;
    logic signed [COORD_W-1:0] clip_end_x;
    logic signed [COORD_W-1:0] clip_end_y;
    logic signed [COORD_W-1:0] clip_end_z;
  } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/lcc_dly.sv
`default_nettype none

module lcc_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    sr_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign dout = sr_r[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/lcc_mul.sv
`default_nettype none

module lcc_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int DG = lcc_pkg::DIGIT;
  localparam int ND = (BW + lcc_pkg::DIGIT - 1) / lcc_pkg::DIGIT;
  localparam int BX = ND * DG;
  localparam int PW = AW + BW;

  logic signed [AW-1:0] a_r   [ND];
  logic signed [BX-1:0] b_r   [ND];
  logic signed [PW-1:0] acc_r [ND];

  for (genvar k = 0; k < ND; k++) begin : g_stage
    logic signed [AW-1:0]    a_in;
    logic signed [BX-1:0]    b_in;
    logic signed [PW-1:0]    acc_in;
    logic signed [DG:0]      dig;
    logic signed [AW+DG:0]   part;
    logic signed [PW-1:0]    part_x;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BX'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    // top digit carries the sign, lower digits are plain magnitudes
    if (k == ND - 1) begin : g_top
      assign dig = $signed({b_in[k*DG+DG-1], b_in[k*DG +: DG]});
    end else begin : g_low
      assign dig = $signed({1'b0, b_in[k*DG +: DG]});
    end

    assign part   = a_in * dig;
    assign part_x = PW'(part) << (k * DG);

    always_ff @(posedge clk) begin
      a_r[k]   <= a_in;
      b_r[k]   <= b_in;
      acc_r[k] <= acc_in + part_x;
    end
  end

  assign p = acc_r[ND-1];

endmodule

`default_nettype wire

>>> rtl/lcc_sqrt.sv
`default_nettype none

module lcc_sqrt #(
  parameter int DIN = 16
) (
  input  logic               clk,
  input  logic [DIN-1:0]     d,
  output logic [DIN/2-1:0]   root
);

  localparam int RW  = DIN / 2;
  localparam int RMW = DIN + 1;

  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_bit
    localparam int K = RW - 1 - i;
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [RMW-1:0] trial;
    logic           take;

    if (i == 0) begin : g_first
      assign rem_in  = RMW'(d);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    // (r + 2^k)^2 - r^2
    assign trial = (RMW'(root_in) << (K + 1)) + (RMW'(1) << (2 * K));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      rem_r[i]  <= take ? rem_in - trial : rem_in;
      root_r[i] <= take ? (root_in | (RW'(1) << K)) : root_in;
    end
  end

  assign root = root_r[RW-1];

endmodule

`default_nettype wire

>>> rtl/lcc_div.sv
`default_nettype none

module lcc_div #(
  parameter int NW = 16,
  parameter int VW = 8,
  parameter int QB = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [VW-1:0] den,
  output logic [QB-1:0] q
);

  localparam int CW = (NW > VW + QB) ? NW : VW + QB;

  logic [CW-1:0] rem_r [QB];
  logic [VW-1:0] den_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_bit
    localparam int K = QB - 1 - i;
    logic [CW-1:0] rem_in;
    logic [VW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic [CW-1:0] sub;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = CW'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign sub  = CW'(den_in) << K;
    assign take = rem_in >= sub;

    always_ff @(posedge clk) begin
      rem_r[i] <= take ? rem_in - sub : rem_in;
      den_r[i] <= den_in;
      q_r[i]   <= take ? (q_in | (QB'(1) << K)) : q_in;
    end
  end

  assign q = q_r[QB-1];

endmodule

`default_nettype wire

>>> rtl/line_cone_clipper.sv
`default_nettype none

// Clips one Q16.16 segment per clock while busy is low against the forward cone
// axial*z^2 - radial*(x^2+y^2) >= 0 with exact integer arithmetic. A new segment is
// taken in every cycle with start high and busy low; busy is registered high during
// reset and is cleared at the clock edge that follows it.
// Each segment yields exactly one result beat on out_valid once it has passed the
// pipeline (for 32-bit coordinates): the bulk of it is the 86-stage square root of the
// discriminant and the 33-stage dividers of the endpoint interpolation, plus the
// 16-bit-digit multiplier stages. Results cannot be held off, so the consumer must
// take every beat in the cycle it appears. Gain registers are written through the
// cfg port and may only change while no segment is in flight.

`include "line_cone_clipper_assert.svh"

module line_cone_clipper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lcc_pkg::in_beat_t           in_beat,
  output logic                        out_valid,
  output lcc_pkg::out_beat_t          out_beat,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [lcc_pkg::GAIN_W-1:0]  cfg_data
);

  localparam int W    = lcc_pkg::COORD_W;
  localparam int G    = lcc_pkg::GAIN_W;
  localparam int DW   = W + 1;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 1;
  localparam int GBW  = G + 1;
  localparam int GPW  = SUMW + GBW;
  localparam int QW   = GPW + 1;
  localparam int NW   = QW + 1;
  localparam int ZW   = NW + DW + 1;
  localparam int PW   = QW + DW;
  localparam int NUMW = PW + 1;
  localparam int GEOW = 6 * W + 3 * DW;

  localparam int LG = (GBW + lcc_pkg::DIGIT - 1) / lcc_pkg::DIGIT;
  localparam int LQ = (QW + lcc_pkg::DIGIT - 1) / lcc_pkg::DIGIT;
  localparam int LZ = (DW + lcc_pkg::DIGIT - 1) / lcc_pkg::DIGIT;
  localparam int LS = QW;
  localparam int LD = DW;

  localparam int S_A = 3 + LG + 1;
  localparam int S_D = S_A + LQ + 1;
  localparam int S_N = S_D + LS + 1;
  localparam int S_Z = S_N + LZ + 1;
  localparam int S_T = S_Z + 1;
  localparam int S_M = S_T + LZ + 1;
  localparam int S_O = S_M + LD + 1;

  function automatic logic [W-1:0] sat_add(logic [W-1:0] p, logic [DW-1:0] q, logic neg);
    logic signed [DW+1:0] px;
    logic signed [DW+1:0] qx;
    logic signed [DW+1:0] res;
    logic [W-1:0]         r;
    px  = (DW+2)'($signed(p));
    qx  = $signed({2'b00, q});
    res = neg ? px - qx : px + qx;
    if (res[DW+1] && !(&res[DW+1:W-1])) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else if (!res[DW+1] && (|res[DW+1:W-1])) begin
      r = {1'b0, {(W-1){1'b1}}};
    end else begin
      r = res[W-1:0];
    end
    return r;
  endfunction

  // control and gains

  logic           busy_r;
  logic           in_accept;
  logic [S_O-1:0] vld_r;
  logic [G-1:0]   radial_r;
  logic [G-1:0]   axial_r;

  assign in_accept = start & ~busy_r;
  assign busy      = busy_r;
  assign out_valid = vld_r[S_O-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[S_O-2:0], in_accept};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radial_r <= lcc_pkg::RADIAL_RESET;
      axial_r  <= lcc_pkg::AXIAL_RESET;
    end else if (cfg_we) begin
      unique case (lcc_pkg::cfg_reg_t'(cfg_index))
        lcc_pkg::CFG_RADIAL: radial_r <= cfg_data;
        lcc_pkg::CFG_AXIAL:  axial_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: direction

  logic [2:0][W-1:0]  pin;
  logic [2:0][W-1:0]  ein;
  logic [2:0][W-1:0]  p1_r;
  logic [2:0][W-1:0]  e1_r;
  logic [2:0][DW-1:0] d1_r;

  assign pin = {in_beat.start_z, in_beat.start_y, in_beat.start_x};
  assign ein = {in_beat.end_z, in_beat.end_y, in_beat.end_x};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p1_r[i] <= pin[i];
      e1_r[i] <= ein[i];
      d1_r[i] <= DW'($signed(ein[i])) - DW'($signed(pin[i]));
    end
  end

  // stage 2: squares and cross terms

  logic [2:0][SQW-1:0] dd2_r;
  logic [2:0][SQW-1:0] dp2_r;
  logic [2:0][SQW-1:0] pp2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd2_r[i] <= $signed(d1_r[i]) * $signed(d1_r[i]);
      dp2_r[i] <= $signed(d1_r[i]) * $signed(p1_r[i]);
      pp2_r[i] <= $signed(p1_r[i]) * $signed(p1_r[i]);
    end
  end

  // stage 3: axial and radial terms, even index axial, odd radial

  logic [5:0][SUMW-1:0] trm3_r;
  logic [5:0][GPW-1:0]  gp;

  always_ff @(posedge clk) begin
    trm3_r[0] <= SUMW'($signed(dd2_r[2]));
    trm3_r[1] <= SUMW'($signed(dd2_r[0])) + SUMW'($signed(dd2_r[1]));
    trm3_r[2] <= SUMW'($signed(dp2_r[2]));
    trm3_r[3] <= SUMW'($signed(dp2_r[0])) + SUMW'($signed(dp2_r[1]));
    trm3_r[4] <= SUMW'($signed(pp2_r[2]));
    trm3_r[5] <= SUMW'($signed(pp2_r[0])) + SUMW'($signed(pp2_r[1]));
  end

  for (genvar j = 0; j < 6; j++) begin : g_gain
    lcc_mul #(.AW(SUMW), .BW(GBW)) u_mul (
      .clk (clk),
      .a   ($signed(trm3_r[j])),
      .b   ($signed({1'b0, ((j % 2) == 0) ? axial_r : radial_r})),
      .p   (gp[j])
    );
  end

  // quadratic coefficients

  logic signed [QW-1:0]   a_r;
  logic signed [QW-1:0]   b_r;
  logic signed [QW-1:0]   c_r;
  logic signed [2*QW-1:0] bb;
  logic signed [2*QW-1:0] ac;
  logic [2*QW-1:0]        ab_q;

  always_ff @(posedge clk) begin
    a_r <= QW'($signed(gp[0])) - QW'($signed(gp[1]));
    b_r <= QW'($signed(gp[2])) - QW'($signed(gp[3]));
    c_r <= QW'($signed(gp[4])) - QW'($signed(gp[5]));
  end

  lcc_mul #(.AW(QW), .BW(QW)) u_mul_bb (.clk(clk), .a(b_r), .b(b_r), .p(bb));
  lcc_mul #(.AW(QW), .BW(QW)) u_mul_ac (.clk(clk), .a(a_r), .b(c_r), .p(ac));
  lcc_dly #(.WIDTH(2*QW), .DEPTH(LQ)) u_dly_ab (.clk(clk), .din({a_r, b_r}), .dout(ab_q));

  // discriminant, orient so that A > 0

  logic signed [2*QW:0]   d_full;
  logic signed [QW-1:0]   a_q;
  logic signed [QW-1:0]   b_q;
  logic [2*QW-1:0]        dm_r;
  logic [QW-1:0]          an_r;
  logic signed [QW-1:0]   bn_r;
  logic                   ok_d_r;

  assign a_q    = $signed(ab_q[2*QW-1:QW]);
  assign b_q    = $signed(ab_q[QW-1:0]);
  assign d_full = (2*QW+1)'(bb) - (2*QW+1)'(ac);

  always_ff @(posedge clk) begin
    dm_r   <= d_full[2*QW-1:0];
    ok_d_r <= !d_full[2*QW] && (d_full != '0) && (a_q != '0);
    an_r   <= a_q[QW-1] ? QW'(-a_q) : QW'(a_q);
    bn_r   <= a_q[QW-1] ? -b_q : b_q;
  end

  // square root

  logic [QW-1:0]       root;
  logic [2*QW:0]       abs_q;

  lcc_sqrt #(.DIN(2*QW)) u_sqrt (.clk(clk), .d(dm_r), .root(root));
  lcc_dly #(.WIDTH(2*QW+1), .DEPTH(LS)) u_dly_abs (
    .clk  (clk),
    .din  ({an_r, bn_r, ok_d_r}),
    .dout (abs_q)
  );

  // root numerators

  logic signed [NW-1:0] bx_s;
  logic signed [NW-1:0] rx_s;
  logic [QW-1:0]        a_n_r;
  logic signed [NW-1:0] nlo_r;
  logic signed [NW-1:0] nhi_r;
  logic                 ok_n_r;

  assign bx_s = NW'($signed(abs_q[QW:1]));
  assign rx_s = $signed({1'b0, root});

  always_ff @(posedge clk) begin
    a_n_r  <= abs_q[2*QW:QW+1];
    nlo_r  <= -bx_s - rx_s;
    nhi_r  <= -bx_s + rx_s;
    ok_n_r <= abs_q[0];
  end

  // forward nappe test

  logic [GEOW-1:0]       geo1;
  logic [GEOW-1:0]       geo_n;
  logic [GEOW-1:0]       geo_t;
  logic [GEOW-1:0]       geo_o;
  logic signed [DW-1:0]  pz_n;
  logic signed [DW-1:0]  dz_n;
  logic signed [NW+DW-1:0] pa;
  logic signed [NW+DW-1:0] dlo;
  logic signed [NW+DW-1:0] dhi;
  logic [QW+2*NW:0]      nz_q;

  assign geo1 = {p1_r, e1_r, d1_r};

  lcc_dly #(.WIDTH(GEOW), .DEPTH(S_N - 1)) u_dly_geo_n (
    .clk(clk), .din(geo1), .dout(geo_n)
  );
  lcc_dly #(.WIDTH(GEOW), .DEPTH(S_T - S_N)) u_dly_geo_t (
    .clk(clk), .din(geo_n), .dout(geo_t)
  );
  lcc_dly #(.WIDTH(GEOW), .DEPTH(S_M + LD - S_T)) u_dly_geo_o (
    .clk(clk), .din(geo_t), .dout(geo_o)
  );

  assign pz_n = DW'($signed(geo_n[GEOW-1 -: W]));
  assign dz_n = $signed(geo_n[3*DW-1 -: DW]);

  lcc_mul #(.AW(NW), .BW(DW)) u_mul_pa (
    .clk(clk), .a($signed({1'b0, a_n_r})), .b(pz_n), .p(pa)
  );
  lcc_mul #(.AW(NW), .BW(DW)) u_mul_lo (.clk(clk), .a(nlo_r), .b(dz_n), .p(dlo));
  lcc_mul #(.AW(NW), .BW(DW)) u_mul_hi (.clk(clk), .a(nhi_r), .b(dz_n), .p(dhi));
  lcc_dly #(.WIDTH(QW+2*NW+1), .DEPTH(LZ)) u_dly_nz (
    .clk  (clk),
    .din  ({a_n_r, nlo_r, nhi_r, ok_n_r}),
    .dout (nz_q)
  );

  logic signed [ZW-1:0] zs_lo;
  logic signed [ZW-1:0] zs_hi;
  logic                 zlo_r;
  logic                 zhi_r;
  logic [QW-1:0]        a_z_r;
  logic signed [NW-1:0] nlo_z_r;
  logic signed [NW-1:0] nhi_z_r;
  logic                 ok_z_r;

  assign zs_lo = ZW'(pa) + ZW'(dlo);
  assign zs_hi = ZW'(pa) + ZW'(dhi);

  always_ff @(posedge clk) begin
    zlo_r   <= zs_lo > 0;
    zhi_r   <= zs_hi > 0;
    a_z_r   <= nz_q[QW+2*NW:2*NW+1];
    nlo_z_r <= $signed(nz_q[2*NW:NW+1]);
    nhi_z_r <= $signed(nz_q[NW:1]);
    ok_z_r  <= nz_q[0];
  end

  // parameter interval

  logic signed [NW-1:0] ax;
  logic signed [NW-1:0] t0_nxt;
  logic signed [NW-1:0] t1_nxt;
  logic                 rej_nxt;
  logic [QW-1:0]        t0_r;
  logic [QW-1:0]        t1_r;
  logic [QW-1:0]        a_t_r;
  logic                 u0_r;
  logic                 u1_r;
  logic                 ok_t_r;

  always_comb begin
    ax      = $signed({1'b0, a_z_r});
    rej_nxt = 1'b0;
    t0_nxt  = '0;
    t1_nxt  = ax;
    priority if (zlo_r && zhi_r) begin
      rej_nxt = (nlo_z_r > ax) || (nhi_z_r < 0);
      t0_nxt  = (nlo_z_r < 0) ? '0 : nlo_z_r;
      t1_nxt  = (nhi_z_r > ax) ? ax : nhi_z_r;
    end else if (zlo_r) begin
      rej_nxt = nlo_z_r < 0;
      t1_nxt  = (nlo_z_r > ax) ? ax : nlo_z_r;
    end else if (zhi_r) begin
      rej_nxt = nhi_z_r > ax;
      t0_nxt  = (nhi_z_r < 0) ? '0 : nhi_z_r;
    end else begin
      rej_nxt = 1'b1;
    end
    if (t0_nxt == t1_nxt) begin
      rej_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    t0_r   <= t0_nxt[QW-1:0];
    t1_r   <= t1_nxt[QW-1:0];
    a_t_r  <= a_z_r;
    u0_r   <= t0_nxt > 0;
    u1_r   <= t1_nxt < ax;
    ok_t_r <= ok_z_r && !rej_nxt;
  end

  // interpolation products, start side then end side

  logic [2:0][DW-1:0] d_t;
  logic [5:0][PW-1:0] prod;
  logic [QW+2:0]      at_q;

  assign d_t = geo_t[3*DW-1:0];

  for (genvar j = 0; j < 6; j++) begin : g_lerp
    lcc_mul #(.AW(QW), .BW(DW)) u_mul (
      .clk (clk),
      .a   ($signed((j < 3) ? t0_r : t1_r)),
      .b   ($signed(d_t[j % 3])),
      .p   (prod[j])
    );
  end

  lcc_dly #(.WIDTH(QW+3), .DEPTH(LZ)) u_dly_at (
    .clk  (clk),
    .din  ({a_t_r, u0_r, u1_r, ok_t_r}),
    .dout (at_q)
  );

  // rounded division by A

  logic [5:0][NUMW-1:0] num_r;
  logic [5:0]           neg_r;
  logic [QW-1:0]        den_r;
  logic                 u0_m_r;
  logic                 u1_m_r;
  logic                 ok_m_r;
  logic [5:0][DW-1:0]   quo;
  logic [8:0]           m_q;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 6; j++) begin
      neg_r[j] <= prod[j][PW-1];
      num_r[j] <= {(prod[j][PW-1] ? PW'(-$signed(prod[j])) : prod[j]), 1'b0}
                  + NUMW'(at_q[QW+2:3]);
    end
    den_r  <= {at_q[QW+1:3], 1'b0};
    u0_m_r <= at_q[2];
    u1_m_r <= at_q[1];
    ok_m_r <= at_q[0];
  end

  for (genvar j = 0; j < 6; j++) begin : g_div
    lcc_div #(.NW(NUMW), .VW(QW), .QB(DW)) u_div (
      .clk (clk),
      .num (num_r[j]),
      .den (den_r),
      .q   (quo[j])
    );
  end

  lcc_dly #(.WIDTH(9), .DEPTH(LD)) u_dly_m (
    .clk  (clk),
    .din  ({neg_r, u0_m_r, u1_m_r, ok_m_r}),
    .dout (m_q)
  );

  // endpoints, saturation and reject

  logic [2:0][W-1:0]  p_o;
  logic [2:0][W-1:0]  e_o;
  logic [2:0][W-1:0]  cs_nxt;
  logic [2:0][W-1:0]  ce_nxt;
  lcc_pkg::out_beat_t out_nxt;
  lcc_pkg::out_beat_t out_r;
  logic               rej_clean;

  assign p_o = geo_o[GEOW-1 -: 3*W];
  assign e_o = geo_o[3*DW +: 3*W];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cs_nxt[j] = m_q[2] ? sat_add(p_o[j], quo[j], m_q[3+j]) : p_o[j];
      ce_nxt[j] = m_q[1] ? sat_add(p_o[j], quo[3+j], m_q[6+j]) : e_o[j];
    end
    out_nxt = '0;
    if (m_q[0]) begin
      out_nxt.accepted     = 1'b1;
      out_nxt.clip_start_x = cs_nxt[0];
      out_nxt.clip_start_y = cs_nxt[1];
      out_nxt.clip_start_z = cs_nxt[2];
      out_nxt.clip_end_x   = ce_nxt[0];
      out_nxt.clip_end_y   = ce_nxt[1];
      out_nxt.clip_end_z   = ce_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_beat  = out_r;
  assign rej_clean = out_beat.accepted || (out_beat[6*W-1:0] == '0);

  `LCC_ASSERT_NOW(a_interval_order, vld_r[S_T-1] && ok_t_r, t0_r < t1_r, "empty clip interval")
  `LCC_ASSERT_NOW(a_reject_zero, out_valid, rej_clean, "rejected beat carries coordinates")
  `LCC_ASSERT_NOW(a_result_origin, out_valid, $past(in_accept, S_O), "result without input beat")
  `LCC_ASSERT_NEXT(a_busy_release, !busy, !busy, "busy reasserted outside reset")

endmodule

`default_nettype wire

>>> tb/line_cone_clipper_test.sv
`default_nettype none

module line_cone_clipper_test;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 200;

  typedef logic signed [255:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lcc_pkg::in_beat_t in_beat = '0;
  logic out_valid;
  lcc_pkg::out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = lcc_pkg::CFG_RADIAL;
  logic [lcc_pkg::GAIN_W-1:0] cfg_data = '0;

  logic [lcc_pkg::GAIN_W-1:0] radial_gain = lcc_pkg::RADIAL_RESET;
  logic [lcc_pkg::GAIN_W-1:0] axial_gain = lcc_pkg::AXIAL_RESET;
  lcc_pkg::out_beat_t clip_q[$];
  int mismatches = 0;
  int beats_seen = 0;
  int cycles = 0;

  line_cone_clipper i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic wide_t ext(logic signed [lcc_pkg::COORD_W-1:0] v);
    wide_t r;
    r = v;
    return r;
  endfunction

  function automatic logic [lcc_pkg::COORD_W-1:0] lerp_coord(wide_t p, wide_t d, wide_t t,
                                                             wide_t a);
    wide_t prod, mag, q, res, hi, lo;
    prod = d * t;
    mag = (prod < 0) ? -prod : prod;
    q = (2 * mag + a) / (2 * a);
    res = (prod < 0) ? p - q : p + q;
    hi = (wide_t'(1) <<< (lcc_pkg::COORD_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (lcc_pkg::COORD_W - 1));
    if (res > hi) res = hi;
    if (res < lo) res = lo;
    return res[lcc_pkg::COORD_W-1:0];
  endfunction

  function automatic lcc_pkg::out_beat_t clip_segment(lcc_pkg::in_beat_t s);
    wide_t p[3], e[3], d[3], rg, ag, a, b, c, disc, root, c2, nlo, nhi, t0, t1;
    logic zlo, zhi;
    lcc_pkg::out_beat_t r;
    r = '0;
    p[0] = ext(s.start_x); p[1] = ext(s.start_y); p[2] = ext(s.start_z);
    e[0] = ext(s.end_x); e[1] = ext(s.end_y); e[2] = ext(s.end_z);
    for (int i = 0; i < 3; i++) d[i] = e[i] - p[i];
    rg = {239'd0, radial_gain};
    ag = {239'd0, axial_gain};
    a = ag * d[2] * d[2] - rg * (d[0] * d[0] + d[1] * d[1]);
    b = ag * d[2] * p[2] - rg * (d[0] * p[0] + d[1] * p[1]);
    c = ag * p[2] * p[2] - rg * (p[0] * p[0] + p[1] * p[1]);
    disc = b * b - a * c;
    if (disc <= 0 || a == 0) return r;
    if (a < 0) begin
      a = -a;
      b = -b;
    end
    root = 0;
    for (int k = 127; k >= 0; k--) begin
      c2 = root | (wide_t'(1) <<< k);
      if ($unsigned(c2 * c2) <= $unsigned(disc)) root = c2;
    end
    nlo = -b - root;
    nhi = -b + root;
    zlo = (p[2] * a + d[2] * nlo) > 0;
    zhi = (p[2] * a + d[2] * nhi) > 0;
    if (zlo && zhi) begin
      if (nlo > a || nhi < 0) return r;
      t0 = (nlo < 0) ? 0 : nlo;
      t1 = (nhi > a) ? a : nhi;
    end else if (zlo) begin
      if (nlo < 0) return r;
      t0 = 0;
      t1 = (nlo > a) ? a : nlo;
    end else if (zhi) begin
      if (nhi > a) return r;
      t0 = (nhi < 0) ? 0 : nhi;
      t1 = a;
    end else begin
      return r;
    end
    if (t0 == t1) return r;
    r.accepted = 1'b1;
    r.clip_start_x = (t0 > 0) ? lerp_coord(p[0], d[0], t0, a) : s.start_x;
    r.clip_start_y = (t0 > 0) ? lerp_coord(p[1], d[1], t0, a) : s.start_y;
    r.clip_start_z = (t0 > 0) ? lerp_coord(p[2], d[2], t0, a) : s.start_z;
    r.clip_end_x = (t1 < a) ? lerp_coord(p[0], d[0], t1, a) : s.end_x;
    r.clip_end_y = (t1 < a) ? lerp_coord(p[1], d[1], t1, a) : s.end_y;
    r.clip_end_z = (t1 < a) ? lerp_coord(p[2], d[2], t1, a) : s.end_z;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch beat %0d %s: got %h want %h", beats_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lcc_pkg::out_beat_t w;
    if (rst_n && out_valid) begin
      if (clip_q.size() == 0) begin
        report("unexpected beat", out_beat.clip_start_x, 0);
      end else begin
        w = clip_q.pop_front();
        if (out_beat.accepted !== w.accepted) report("accepted", out_beat.accepted, w.accepted);
        if (out_beat.clip_start_x !== w.clip_start_x)
          report("clip_start_x", out_beat.clip_start_x, w.clip_start_x);
        if (out_beat.clip_start_y !== w.clip_start_y)
          report("clip_start_y", out_beat.clip_start_y, w.clip_start_y);
        if (out_beat.clip_start_z !== w.clip_start_z)
          report("clip_start_z", out_beat.clip_start_z, w.clip_start_z);
        if (out_beat.clip_end_x !== w.clip_end_x)
          report("clip_end_x", out_beat.clip_end_x, w.clip_end_x);
        if (out_beat.clip_end_y !== w.clip_end_y)
          report("clip_end_y", out_beat.clip_end_y, w.clip_end_y);
        if (out_beat.clip_end_z !== w.clip_end_z)
          report("clip_end_z", out_beat.clip_end_z, w.clip_end_z);
      end
      beats_seen++;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_segment(lcc_pkg::in_beat_t s);
    start = 1'b1;
    in_beat = s;
    // busy only moves at a rising edge, so its value here holds at the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    clip_q.push_back(clip_segment(s));
    @(negedge clk);
  endtask

  task automatic pause(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (clip_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_gain(lcc_pkg::cfg_reg_t idx, logic [lcc_pkg::GAIN_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == lcc_pkg::CFG_RADIAL) radial_gain = v;
    else axial_gain = v;
  endtask

  function automatic logic signed [31:0] rand_coord();
    unique case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 32'h0000ffff)) - 32'sh00008000;
      default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic lcc_pkg::in_beat_t rand_segment();
    lcc_pkg::in_beat_t s;
    s.start_x = rand_coord(); s.start_y = rand_coord(); s.start_z = rand_coord();
    s.end_x = rand_coord(); s.end_y = rand_coord(); s.end_z = rand_coord();
    // bias z forward so that many segments reach the cone
    if ($urandom_range(0, 2) != 0) begin
      s.start_z = $urandom_range(0, 32'h01ffffff);
      s.end_z = $urandom_range(0, 32'h01ffffff);
    end
    return s;
  endfunction

  function automatic lcc_pkg::in_beat_t seg(int sx, int sy, int sz, int ex, int ey, int ez);
    lcc_pkg::in_beat_t s;
    s.start_x = sx <<< 16; s.start_y = sy <<< 16; s.start_z = sz <<< 16;
    s.end_x = ex <<< 16; s.end_y = ey <<< 16; s.end_z = ez <<< 16;
    return s;
  endfunction

  task automatic test_directed();
    lcc_pkg::in_beat_t s;
    send_segment('0);
    send_segment({6{32'sh7fffffff}});
    send_segment({6{32'sh80000000}});
    send_segment({32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_segment({32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 32'sh7fffffff, 32'sh00000001});
    send_segment(seg(0, 0, 1, 0, 0, 10));
    send_segment(seg(0, 0, -10, 0, 0, 10));
    send_segment(seg(0, 0, 10, 0, 0, -10));
    send_segment(seg(0, 0, -10, 0, 0, -1));
    send_segment(seg(-100, 0, 10, 100, 0, 10));
    send_segment(seg(100, 3, 10, -100, -3, 10));
    send_segment(seg(0, -50, 20, 0, 50, 40));
    send_segment(seg(-100, 0, -10, 100, 0, -10));
    send_segment(seg(0, 0, 10, 0, 0, 10));
    send_segment(seg(5, 5, 5, 5, 5, 5));
    send_segment(seg(-20, 0, 1, 20, 0, 50));
    send_segment(seg(1, 1, 100, 500, 500, 100));
    send_segment(seg(500, 500, 100, 1, 1, 100));
    send_segment(seg(30, 0, -40, -30, 0, 40));
    send_segment(seg(0, 0, 0, 10, 0, 10));
    send_segment(seg(3, 4, 4, 3, 4, 6));
    s = seg(0, 0, 1, 0, 0, 2);
    s.end_z = 32'sh7fffffff;
    send_segment(s);
    wait_idle();
  endtask

  task automatic test_random(int n, bit with_gaps);
    for (int i = 0; i < n; i++) begin
      send_segment(rand_segment());
      if (with_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 16));
    end
    wait_idle();
  endtask

  task automatic test_gains();
    logic [lcc_pkg::GAIN_W-1:0] rv[6] = '{17'd0, 17'h1ffff, 17'd1, 17'h1ffff, 17'd0, 17'd65536};
    logic [lcc_pkg::GAIN_W-1:0] av[6] = '{17'h1ffff, 17'd0, 17'h1ffff, 17'd1, 17'd0, 17'd65536};
    for (int k = 0; k < 6; k++) begin
      write_gain(lcc_pkg::CFG_RADIAL, rv[k]);
      write_gain(lcc_pkg::CFG_AXIAL, av[k]);
      test_random(40, 1'b1);
    end
    for (int k = 0; k < 3; k++) begin
      write_gain(lcc_pkg::CFG_RADIAL, (lcc_pkg::GAIN_W)'($urandom_range(0, 17'h1ffff)));
      write_gain(lcc_pkg::CFG_AXIAL, (lcc_pkg::GAIN_W)'($urandom_range(0, 17'h1ffff)));
      test_random(60, 1'b1);
    end
    write_gain(lcc_pkg::CFG_RADIAL, lcc_pkg::RADIAL_RESET);
    write_gain(lcc_pkg::CFG_AXIAL, lcc_pkg::AXIAL_RESET);
  endtask

  task automatic test_pause_mid_stream();
    test_random(30, 1'b1);
    test_random(30, 1'b0);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(300, 1'b1);
    test_gains();
    test_pause_mid_stream();
    test_random(250, 1'b0);
    wait_idle();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
